>>> rtl/core/cfce_pkg.sv
`default_nettype none

package cfce_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int CHAN_W = 2;
	localparam int CHAN_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LEVEL_W = 16;
	localparam int RAND_W = 31;
	localparam int THR_W = 31;
	localparam int SUM_W = LEVEL_W + 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	localparam int DELTA_WINDOW = 7500;
	localparam int REM_W = (DELTA_WINDOW > 1) ? $clog2(DELTA_WINDOW) : 1;

	// r mod DELTA_WINDOW through a reciprocal: q = (r * RECIP_MULT) >> RECIP_SHIFT is exact
	// for every r below 2^RAND_W
	localparam int RECIP_SHIFT = RAND_W + REM_W;
	localparam int RECIP_W = RAND_W + 1;
	localparam int QUO_W = RAND_W - REM_W + 1;
	localparam int PROD_W = RAND_W + RECIP_W;
	localparam logic [63:0] RECIP_MULT =
		((64'd1 << RECIP_SHIFT) + 64'(DELTA_WINDOW) - 64'd1) / 64'(DELTA_WINDOW);

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd30000;
	localparam logic [LEVEL_W-1:0] FLOOR_RESET = 16'd12000;
	localparam logic [LEVEL_W-1:0] CEILING_RESET = 16'd60000;
	localparam logic [LEVEL_W-1:0] DESCEND_RESET = 16'd12000;
	localparam logic [LEVEL_W-1:0] ASCEND_RESET = 16'd20000;
	localparam logic [LEVEL_W-1:0] RETURN_RESET = 16'd20000;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 31'd10737418;

	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_LEVEL_FLOOR = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEVEL_CEILING = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DESCEND_STEP = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ASCEND_STEP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RETURN_STEP = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 3'd5;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DESC = 2'd1,
		PH_ASC  = 2'd2,
		PH_RET  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_floor;
		logic [LEVEL_W-1:0] level_ceiling;
		logic [LEVEL_W-1:0] descend_step;
		logic [LEVEL_W-1:0] ascend_step;
		logic [LEVEL_W-1:0] return_step;
		logic [THR_W-1:0]   trigger_threshold;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		phase_t             phase;
		logic [LEVEL_W-1:0] saved_level;
		logic               return_up;
	} chan_state_t;

endpackage

`default_nettype wire

>>> rtl/core/candle_flicker_channel_engine.sv
// candle flicker channel engine
// s_* carries one tick for one led channel: tdata[1:0] chan, tdata[32:2] random_value.
// m_* returns one item per tick: tdata[1:0] out_chan, [17:2] level, [19:18] phase.
// registers sit on the apb port, byte address 4*index; pready is always high.
// three register stages: input, quotient of random_value mod the walk window
// (one 31x32 constant multiply), then the per-channel update into the result
// register. throughput is one item per clock while results are taken; the
// channel read-modify-write is done in the last stage, so ticks for the same
// channel may follow back to back.
// at reset every channel is idle at level 30000 and the registers take their
// reset values. when m_tready is low the stages keep filling; s_tready drops
// once input, quotient and result stages all hold an item.
// a channel number at or above the channel count changes nothing and reports
// level 0 in the idle phase.
`default_nettype none

module candle_flicker_channel_engine
	import cfce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // chan[1:0], random_value[32:2], zero
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // out_chan[1:0], level[17:2], phase[19:18], zero
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	cfg_t cfg;

	logic              valid_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [RAND_W-1:0] rand_s1;
	logic [PROD_W-1:0] s1_prod;

	logic              valid_s2;
	logic [CHAN_W-1:0] chan_s2;
	logic [RAND_W-1:0] rand_s2;
	logic [QUO_W-1:0]  quo_s2;

	logic               out_v_q;
	logic [CHAN_W-1:0]  out_chan_q;
	logic [LEVEL_W-1:0] out_level_q;
	phase_t             out_phase_q;

	logic out_ready;
	logic s2_ready;
	logic s1_ready;
	logic s2_fire;
	logic chan_ok;
	logic commit;

	logic [CHAN_IDX_W-1:0] idx;
	chan_state_t           st_q [NUM_CHANNELS];
	chan_state_t           cur;
	chan_state_t           nxt;

	cfce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_ready = !out_v_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign s_tready  = s1_ready;
	assign s2_fire   = valid_s2 && out_ready;

	assign s1_prod = PROD_W'(rand_s1) * PROD_W'(RECIP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (s1_ready) valid_s1 <= s_tvalid;
			if (s2_ready) valid_s2 <= valid_s1;
			if (out_ready) out_v_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_ready) begin
			chan_s1 <= s_tdata[CHAN_W-1:0];
			rand_s1 <= s_tdata[CHAN_W+RAND_W-1:CHAN_W];
		end
		if (valid_s1 && s2_ready) begin
			chan_s2 <= chan_s1;
			rand_s2 <= rand_s1;
			quo_s2  <= s1_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
		end
		if (s2_fire) begin
			out_chan_q  <= chan_s2;
			out_level_q <= chan_ok ? nxt.level : '0;
			out_phase_q <= chan_ok ? nxt.phase : PH_IDLE;
		end
	end

	assign chan_ok = int'(chan_s2) < NUM_CHANNELS;
	assign idx     = chan_s2[CHAN_IDX_W-1:0];
	assign cur     = chan_ok ? st_q[idx] : '0;
	assign commit  = s2_fire && chan_ok;

	cfce_update u_update (
		.cfg          (cfg),
		.cur          (cur),
		.random_value (rand_s2),
		.quo          (quo_s2),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				st_q[i].level       <= LEVEL_RESET;
				st_q[i].phase       <= PH_IDLE;
				st_q[i].saved_level <= '0;
				st_q[i].return_up   <= 1'b0;
			end
		end else if (commit) begin
			st_q[idx] <= nxt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_TDATA_W - CHAN_W - LEVEL_W - 2){1'b0}},
	                   out_phase_q, out_level_q, out_chan_q};

`ifndef SYNTHESIS
	a_phase_order: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (nxt.phase == cur.phase || nxt.phase == phase_t'(cur.phase + 2'd1)))
		else $error("channel phase skipped a step");

	a_save_on_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && cur.phase == PH_IDLE && nxt.phase == PH_DESC)
		|-> (nxt.saved_level == nxt.level))
		else $error("saved level differs from level at flicker start");

	a_ceiling_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && cur.phase == PH_ASC && nxt.phase == PH_RET)
		|-> (nxt.level == cfg.level_ceiling))
		else $error("ascent did not clamp at the ceiling");

	a_bad_chan_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && int'(out_chan_q) >= NUM_CHANNELS)
		|-> (out_level_q == '0 && out_phase_q == PH_IDLE))
		else $error("out of range channel reported a level");
`endif

endmodule

`default_nettype wire

>>> rtl/core/cfce_regs.sv
`default_nettype none

module cfce_regs
	import cfce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.level_floor       <= FLOOR_RESET;
			cfg.level_ceiling     <= CEILING_RESET;
			cfg.descend_step      <= DESCEND_RESET;
			cfg.ascend_step       <= ASCEND_RESET;
			cfg.return_step       <= RETURN_RESET;
			cfg.trigger_threshold <= THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LEVEL_FLOOR:       cfg.level_floor <= pwdata[LEVEL_W-1:0];
				REG_LEVEL_CEILING:     cfg.level_ceiling <= pwdata[LEVEL_W-1:0];
				REG_DESCEND_STEP:      cfg.descend_step <= pwdata[LEVEL_W-1:0];
				REG_ASCEND_STEP:       cfg.ascend_step <= pwdata[LEVEL_W-1:0];
				REG_RETURN_STEP:       cfg.return_step <= pwdata[LEVEL_W-1:0];
				REG_TRIGGER_THRESHOLD: cfg.trigger_threshold <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEVEL_FLOOR:       prdata = 32'(cfg.level_floor);
			REG_LEVEL_CEILING:     prdata = 32'(cfg.level_ceiling);
			REG_DESCEND_STEP:      prdata = 32'(cfg.descend_step);
			REG_ASCEND_STEP:       prdata = 32'(cfg.ascend_step);
			REG_RETURN_STEP:       prdata = 32'(cfg.return_step);
			REG_TRIGGER_THRESHOLD: prdata = 32'(cfg.trigger_threshold);
			default:               prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/cfce_update.sv
`default_nettype none

module cfce_update
	import cfce_pkg::*;
(
	input  wire cfg_t               cfg,
	input  wire chan_state_t        cur,
	input  wire logic [RAND_W-1:0]  random_value,
	input  wire logic [QUO_W-1:0]   quo,
	output chan_state_t             nxt
);

	localparam logic [LEVEL_W+REM_W-1:0] DW_EXT = (LEVEL_W + REM_W)'(DELTA_WINDOW);
	localparam logic [RAND_W-1:0]        DW_R = RAND_W'(DELTA_WINDOW);

	logic [RAND_W-1:0]        quo_dw;
	logic [RAND_W-1:0]        rem_full;
	logic [REM_W-1:0]         rem;
	logic [LEVEL_W+REM_W-1:0] drain_prod;
	logic [REM_W-1:0]         drain;
	logic [LEVEL_W-1:0]       walk_level;
	logic [SUM_W-1:0]         desc_lim;
	logic signed [SUM_W-1:0]  asc_lim;
	logic signed [SUM_W-1:0]  ret_diff;
	logic [SUM_W-1:0]         ret_abs;

	always_comb begin
		// remainder from the quotient of the previous stage
		quo_dw     = RAND_W'(quo) * DW_R;
		rem_full   = random_value - quo_dw;
		rem        = rem_full[REM_W-1:0];
		drain_prod = (LEVEL_W + REM_W)'(cur.level) * DW_EXT;
		drain      = drain_prod[LEVEL_W+REM_W-1:LEVEL_W];
		walk_level = cur.level + LEVEL_W'(rem) - LEVEL_W'(drain);

		desc_lim = {2'b00, cfg.level_floor} + {2'b00, cfg.descend_step};
		asc_lim  = $signed({2'b00, cfg.level_ceiling}) - $signed({2'b00, cfg.ascend_step});
		ret_diff = $signed({2'b00, cur.level}) - $signed({2'b00, cur.saved_level});
		ret_abs  = ret_diff[SUM_W-1] ? SUM_W'(-ret_diff) : SUM_W'(ret_diff);

		nxt = cur;
		unique case (cur.phase)
			PH_IDLE: begin
				nxt.level = walk_level;
				if (random_value < cfg.trigger_threshold) begin
					nxt.saved_level = walk_level;
					nxt.return_up   = cfg.level_ceiling < walk_level;
					nxt.phase       = PH_DESC;
				end
			end
			PH_DESC: begin
				if ({2'b00, cur.level} > desc_lim) begin
					nxt.level = cur.level - cfg.descend_step;
				end else begin
					nxt.phase = PH_ASC;
				end
			end
			PH_ASC: begin
				if ($signed({2'b00, cur.level}) < asc_lim) begin
					nxt.level = cur.level + cfg.ascend_step;
				end else begin
					nxt.level = cfg.level_ceiling;
					nxt.phase = PH_RET;
				end
			end
			PH_RET: begin
				if (ret_abs > {2'b00, cfg.return_step}) begin
					nxt.level = cur.return_up ? cur.level + cfg.return_step
					                          : cur.level - cfg.return_step;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
	import cfce_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum {SET_RESET_VALUES, SET_SPREAD, SET_ALL_HIGH, SET_ALL_LOW, SET_WIDE} setting_kind_t;

	typedef struct {
		logic [CHAN_W-1:0]  chan;
		logic [LEVEL_W-1:0] level;
		phase_t             phase;
	} tick_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // chan[1:0], random_value[32:2], zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // out_chan[1:0], level[17:2], phase[19:18], zero
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// flicker state and register copy tracked alongside the block
	cfg_t flick_cfg = '{FLOOR_RESET, CEILING_RESET, DESCEND_RESET, ASCEND_RESET,
		RETURN_RESET, THRESHOLD_RESET};
	logic [LEVEL_W-1:0] chan_level_q [NUM_CHANNELS] = '{default: LEVEL_RESET};
	phase_t             chan_phase_q [NUM_CHANNELS] = '{default: PH_IDLE};
	logic [LEVEL_W-1:0] chan_saved_q [NUM_CHANNELS] = '{default: '0};
	logic               chan_up_q    [NUM_CHANNELS] = '{default: 1'b0};

	tick_result_t expected_ticks [$];

	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int flickers_started = 0;
	int off_range_ticks = 0;
	int settings_loaded = 0;
	int quiet_cycles = 0;

	candle_flicker_channel_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tick_result_t advance_channel(input logic [CHAN_W-1:0] ch,
			input logic [RAND_W-1:0] rv);
		tick_result_t res;
		logic [LEVEL_W-1:0] lv;
		phase_t ph;
		int unsigned drain;
		int lv_i, ref_i, step_i, gap;
		res.chan = ch;
		res.level = '0;
		res.phase = PH_IDLE;
		if (ch >= NUM_CHANNELS) begin
			off_range_ticks++;
			return res;
		end
		lv = chan_level_q[ch];
		ph = chan_phase_q[ch];
		lv_i = lv;
		case (ph)
			PH_IDLE: begin
				drain = (32'(lv) * DELTA_WINDOW) >> 16;
				lv = LEVEL_W'(32'(lv) + (32'(rv) % DELTA_WINDOW) - drain);
				if (rv < flick_cfg.trigger_threshold) begin
					chan_saved_q[ch] = lv;
					chan_up_q[ch] = flick_cfg.level_ceiling < lv;
					ph = PH_DESC;
					flickers_started++;
				end
			end
			PH_DESC: begin
				if (32'(lv) > 32'(flick_cfg.level_floor) + 32'(flick_cfg.descend_step))
					lv = lv - flick_cfg.descend_step;
				else
					ph = PH_ASC;
			end
			PH_ASC: begin
				ref_i = flick_cfg.level_ceiling;
				step_i = flick_cfg.ascend_step;
				if (lv_i < ref_i - step_i) begin
					lv = lv + flick_cfg.ascend_step;
				end else begin
					lv = flick_cfg.level_ceiling;
					ph = PH_RET;
				end
			end
			PH_RET: begin
				ref_i = chan_saved_q[ch];
				step_i = flick_cfg.return_step;
				gap = lv_i - ref_i;
				if (gap < 0)
					gap = -gap;
				// a stale direction just wraps around until it lands near the saved level
				if (gap > step_i)
					lv = chan_up_q[ch] ? lv + flick_cfg.return_step : lv - flick_cfg.return_step;
				else
					ph = PH_IDLE;
			end
		endcase
		chan_level_q[ch] = lv;
		chan_phase_q[ch] = ph;
		res.level = lv;
		res.phase = ph;
		return res;
	endfunction

	task automatic wait_for_results;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_ticks.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_tick(input logic [CHAN_W-1:0] ch, input logic [RAND_W-1:0] rv);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - CHAN_W - RAND_W){1'b0}}, rv, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_ticks.push_back(advance_channel(ch, rv));
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		wait_for_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_LEVEL_FLOOR:       flick_cfg.level_floor = val[LEVEL_W-1:0];
			REG_LEVEL_CEILING:     flick_cfg.level_ceiling = val[LEVEL_W-1:0];
			REG_DESCEND_STEP:      flick_cfg.descend_step = val[LEVEL_W-1:0];
			REG_ASCEND_STEP:       flick_cfg.ascend_step = val[LEVEL_W-1:0];
			REG_RETURN_STEP:       flick_cfg.return_step = val[LEVEL_W-1:0];
			REG_TRIGGER_THRESHOLD: flick_cfg.trigger_threshold = val[THR_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input setting_kind_t kind);
		logic [LEVEL_W-1:0] fl, ce, ds, as, rs;
		logic [THR_W-1:0] th;
		case (kind)
			SET_RESET_VALUES: begin
				fl = FLOOR_RESET;
				ce = CEILING_RESET;
				ds = DESCEND_RESET;
				as = ASCEND_RESET;
				rs = RETURN_RESET;
				th = THRESHOLD_RESET;
			end
			SET_SPREAD: begin
				fl = LEVEL_W'($urandom_range(30000));
				ce = LEVEL_W'($urandom_range(65535, 35000));
				ds = LEVEL_W'($urandom_range(25000, 1));
				as = LEVEL_W'($urandom_range(25000, 1));
				rs = LEVEL_W'($urandom_range(25000, 1));
				th = THR_W'($urandom_range(32'h3FFF_FFFF));
			end
			SET_ALL_HIGH: begin
				fl = '1;
				ce = '1;
				ds = '1;
				as = '1;
				rs = '1;
				th = '1;
			end
			SET_ALL_LOW: begin
				fl = '0;
				ce = '0;
				ds = '0;
				as = '0;
				rs = '0;
				th = '0;
			end
			default: begin
				fl = LEVEL_W'($urandom());
				ce = LEVEL_W'($urandom());
				ds = LEVEL_W'($urandom());
				as = LEVEL_W'($urandom());
				rs = LEVEL_W'($urandom());
				th = THR_W'($urandom());
			end
		endcase
		// junk in the unused upper bits must be dropped
		write_reg(REG_LEVEL_FLOOR, {16'($urandom()), fl});
		write_reg(REG_LEVEL_CEILING, {16'($urandom()), ce});
		write_reg(REG_DESCEND_STEP, {16'($urandom()), ds});
		write_reg(REG_ASCEND_STEP, {16'($urandom()), as});
		write_reg(REG_RETURN_STEP, {16'($urandom()), rs});
		write_reg(REG_TRIGGER_THRESHOLD, {1'($urandom()), th});
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
		settings_loaded++;
	endtask

	task automatic run_random_ticks(input int count);
		logic [CHAN_W-1:0] ch;
		logic [RAND_W-1:0] rv;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(149) == 0)
				wait_for_results();
			ch = ($urandom_range(11) == 0) ? CHAN_W'(NUM_CHANNELS)
				: CHAN_W'($urandom_range(NUM_CHANNELS - 1));
			case ($urandom_range(9))
				0, 1, 2: rv = (flick_cfg.trigger_threshold == 0) ? '0
					: RAND_W'($urandom_range(flick_cfg.trigger_threshold - 1));
				3: rv = ($urandom_range(1) == 0) ? '0 : {RAND_W{1'b1}};
				4: rv = RAND_W'($urandom_range(2 * DELTA_WINDOW));
				default: rv = RAND_W'($urandom());
			endcase
			send_tick(ch, rv);
		end
	endtask

	// full flicker on channel 0 with the reset registers
	task automatic test_reset_flicker;
		send_tick(2'd0, '0);
		repeat (7)
			send_tick(2'd0, RAND_W'($urandom()));
		send_tick(2'd0, {RAND_W{1'b1}});
	endtask

	task automatic test_channel_edges;
		send_tick(CHAN_W'(NUM_CHANNELS), '0);
		send_tick(CHAN_W'(NUM_CHANNELS), {RAND_W{1'b1}});
		send_tick(2'd2, RAND_W'(DELTA_WINDOW - 1));
		send_tick(2'd2, RAND_W'(DELTA_WINDOW));
		send_tick(2'd1, {RAND_W{1'b1}});
	endtask

	// ceiling dropped mid-flicker: return steps down from below the saved level and wraps
	task automatic test_wrong_direction_return;
		send_tick(2'd1, '0);
		send_tick(2'd1, RAND_W'($urandom()));
		send_tick(2'd1, RAND_W'($urandom()));
		write_reg(REG_LEVEL_CEILING, 32'd1000);
		repeat (5)
			send_tick(2'd1, RAND_W'($urandom()));
		write_reg(REG_LEVEL_CEILING, 32'(CEILING_RESET));
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct,
			input setting_kind_t first_kind, input int first_count,
			input setting_kind_t second_kind, input int second_count, input int tail_count);
		sender_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		load_settings(first_kind);
		run_random_ticks(first_count);
		load_settings(second_kind);
		run_random_ticks(second_count);
		load_settings(SET_SPREAD);
		run_random_ticks(tail_count);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (expected_ticks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: chan %0d level %0d phase %0d",
						m_tdata[1:0], m_tdata[17:2], m_tdata[19:18]);
			end else begin
				want = expected_ticks.pop_front();
				if (m_tdata[1:0] !== want.chan || m_tdata[17:2] !== want.level
						|| m_tdata[19:18] !== want.phase) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("item %0d: expected chan %0d level %0d phase %0d, got chan %0d level %0d phase %0d",
							results_checked, want.chan, want.level, want.phase,
							m_tdata[1:0], m_tdata[17:2], m_tdata[19:18]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no item moving", quiet_cycles);
			$display("candle_flicker_channel_engine verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 25;
		recv_idle_pct = 80;
		test_reset_flicker();
		test_channel_edges();
		test_wrong_direction_return();

		test_random_traffic(25, 80, SET_SPREAD, 250, SET_ALL_HIGH, 150, 200);
		test_random_traffic(80, 25, SET_ALL_LOW, 150, SET_WIDE, 250, 200);
		test_random_traffic(0, 0, SET_RESET_VALUES, 250, SET_WIDE, 200, 180);

		wait_for_results();
		repeat (8)
			@(posedge clk);
		if (expected_ticks.size() != 0)
			mismatch_count++;

		$display("%0d channel ticks checked, %0d flickers started, %0d off-range ticks, %0d register loads",
			results_checked, flickers_started, off_range_ticks, settings_loaded);
		$display("stall mixes sender/receiver 25/80, 80/25 and none; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("candle_flicker_channel_engine verification clean");
		else
			$display("candle_flicker_channel_engine verification failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/cfce_pkg.sv
rtl/core/cfce_regs.sv
rtl/core/cfce_update.sv
rtl/core/candle_flicker_channel_engine.sv
tb/tb_top.sv
